@@ hdl/mlp_pkg.sv @@
// Package for the two-layer perceptron engine: opcodes, fixed-point helpers
// and the sigmoid table. No dependencies.
package mlp_pkg;

  localparam int unsigned FEAT_MAX = 6;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_WRITE   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture the input item and zero the accumulator
    CMD_DEL,       // t = sat(o - target)
    CMD_MAC_HID,   // acc += w_hidden * x (read data at memory port)
    CMD_HID_DONE,  // activation = sigmoid(sat(acc))
    CMD_MAC_OUT,   // acc += a * w_out
    CMD_OUT_DONE,  // result = sat(acc)
    CMD_G,         // g = eta * del
    CMD_GH1,       // t = g * a
    CMD_GH2,       // t = t * (1 - a)
    CMD_GH3,       // gh = t * w_out
    CMD_UPD_HID,   // w_hidden -= gh * x
    CMD_UPD_OUT,   // w_out -= g * a
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  addr;   // weight memory address
    logic [3:0]  unit;
    logic [2:0]  feat;
    logic        rd;     // address the memory at the item's weight index
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               output logic ovf);
    ovf = 1'b0;
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Rounded Q16.16 product with saturation; floor((a*b + 2^15) / 2^16).
  function automatic logic signed [31:0] fx_round(input logic signed [63:0] p,
                                                  output logic ovf);
    logic signed [65:0] r;
    r = (66'(p) + 66'sd32768) >>> 16;
    return sat32(r, ovf);
  endfunction

  // Sigmoid table index: floor(x*16)+128 clamped to 0..255.
  function automatic logic [7:0] sig_index(input logic signed [31:0] v);
    logic signed [19:0] k;
    k = v[31:12];
    if (k < -20'sd128) return 8'd0;
    if (k > 20'sd127) return 8'd255;
    return 8'(k + 20'sd128);
  endfunction

  // Restoring division, evaluated only while the table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem = rem - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table built at elaboration with the same integer steps as the definition.
  function automatic logic [31:0] sig_entry(input int unsigned k);
    logic [63:0]  p;
    logic [127:0] t;
    logic [63:0]  den;
    int unsigned  m;
    p = 64'h1_0000_0000;
    m = (k >= 128) ? k - 128 : 128 - k;
    for (int i = 0; i < m; i++) begin
      t = 128'(p) * 128'd4034748382 + 128'h8000_0000;
      p = 64'(t >> 32);
    end
    den = 64'h1_0000_0000 + p;
    if (k >= 128) return 32'(div_u64((64'h1 << 48) + (den >> 1), den));
    return 32'(div_u64((p << 16) + (den >> 1), den));
  endfunction

  typedef logic [31:0] sig_tab_t [256];

  function automatic sig_tab_t build_sig();
    sig_tab_t t;
    for (int k = 0; k < 256; k++) t[k] = sig_entry(k);
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig();

endpackage

@@ hdl/mlp_sgd_engine.sv @@
// Top level of the two-layer perceptron engine with SGD training.
// Depends on mlp_pkg, mlp_ctrl, mlp_datapath and mlp_ram.
//
// One item is taken at a time. The pace is set by the single weight memory
// port, which is read for each weight that an item uses, and the one shared
// multiplier. The result waits in an output register, and the next item is
// taken once it has left.
module mlp_sgd_engine
  import mlp_pkg::*;
#(
  parameter int FEATURES     = 6,
  parameter int HIDDEN_UNITS = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], feature_0..feature_5, target, weight_index[5:0], weight_value
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value[31:0]
  output logic [31:0]  out_tdata,
  // saturated
  output logic         out_tuser
);
  logic [15:0] learn_rate_r;
  logic        busy, done, pend_r;
  ctl_t        ctl;
  logic signed [31:0] res_value;
  logic        res_sat;
  logic        start;

  always_ff @(posedge clk) begin
    if (!rst_n) learn_rate_r <= 16'd655;
    else if (cfg_we) learn_rate_r <= cfg_wdata;
  end

  // The cycle after the controller finishes, the result is not yet marked
  // pending, so the input stays closed then as well.
  assign in_tready = !busy && !pend_r && !done;
  assign start = in_tvalid && in_tready;

  mlp_ctrl #(.FEATURES(FEATURES), .HIDDEN_UNITS(HIDDEN_UNITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_tdata[1:0]),
    .busy(busy), .done(done), .ctl(ctl)
  );

  // The input item is held by the sender only for the accept cycle, so
  // capture it here and feed the datapath its load command in the cycle after.
  logic [263:2] item_r;
  always_ff @(posedge clk) begin
    if (start) item_r <= in_tdata[263:2];
  end

  mlp_datapath #(.FEATURES(FEATURES), .HIDDEN_UNITS(HIDDEN_UNITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_feat(item_r[193:2]), .in_target(item_r[225:194]),
    .in_index(item_r[231:226]), .in_wval(item_r[263:232]),
    .learn_rate(learn_rate_r), .res_value(res_value), .res_sat(res_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (done) pend_r <= 1'b1;
    else if (out_tready) pend_r <= 1'b0;
  end

  assign out_tvalid = pend_r;
  assign out_tdata  = res_value;
  assign out_tuser  = res_sat;
endmodule

@@ hdl/mlp_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module mlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/mlp_datapath.sv @@
// Datapath: weight RAM, one shared multiplier, accumulator and activations.
// Depends on mlp_pkg and mlp_ram.
module mlp_datapath
  import mlp_pkg::*;
#(
  parameter int FEATURES     = 6,
  parameter int HIDDEN_UNITS = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctl_t                   ctl,
  input  logic [FEAT_MAX*32-1:0] in_feat,
  input  logic signed [31:0]     in_target,
  input  logic [5:0]             in_index,
  input  logic signed [31:0]     in_wval,
  input  logic [15:0]            learn_rate,
  output logic signed [31:0]     res_value,
  output logic                   res_sat
);
  localparam int NW = HIDDEN_UNITS * FEATURES + HIDDEN_UNITS;
  localparam int AW = $clog2(NW);
  localparam int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic signed [31:0] x_r [FEATURES];
  logic signed [31:0] tgt_r, wval_r;
  logic [5:0]         idx_r;
  logic signed [31:0] act_r [HIDDEN_UNITS];
  logic signed [65:0] acc_r;
  logic signed [31:0] g_r, t_r, value_r;
  logic               sat_r;

  logic               we;
  logic [AW-1:0]      ram_addr;
  logic signed [31:0] wdata, rdata;

  mlp_ram #(.WIDTH(32), .DEPTH(NW)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  // Operand selection for the shared multiplier.
  logic signed [31:0] ma, mb, prod, diff;
  logic               povf, dovf;
  logic signed [31:0] a_cur;

  always_comb begin
    a_cur = act_r[ctl.unit[UW-1:0]];
    ma = rdata;
    mb = x_r[ctl.feat[FW-1:0]];
    case (ctl.cmd)
      CMD_MAC_OUT: begin ma = a_cur; mb = rdata; end
      CMD_G:       begin ma = 32'($unsigned(learn_rate)); mb = t_r; end
      CMD_GH1:     begin ma = g_r; mb = a_cur; end
      CMD_GH2:     begin ma = t_r; mb = 32'sh10000 - a_cur; end
      CMD_GH3:     begin ma = t_r; mb = rdata; end
      CMD_UPD_HID: begin ma = t_r; end
      CMD_UPD_OUT: begin ma = g_r; mb = a_cur; end
      default: ;
    endcase
    prod = fx_round(64'(ma) * 64'(mb), povf);
    diff = sat32(66'(rdata) - 66'(prod), dovf);
    we = 1'b0;
    ram_addr = ctl.addr[AW-1:0];
    wdata = diff;
    if (ctl.rd) ram_addr = AW'(idx_r);
    if (ctl.cmd == CMD_UPD_HID || ctl.cmd == CMD_UPD_OUT) we = 1'b1;
    if (ctl.cmd == CMD_WRITE && idx_r < NW) begin
      we = 1'b1;
      ram_addr = AW'(idx_r);
      wdata = wval_r;
    end
  end

  logic signed [31:0] accsat, delv;
  logic               aovf, delovf;
  always_comb begin
    accsat = sat32(acc_r, aovf);
    delv = sat32(66'(value_r) - 66'(tgt_r), delovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      unique case (ctl.cmd)
        CMD_LOAD: begin
          for (int j = 0; j < FEATURES; j++) x_r[j] <= in_feat[j*32 +: 32];
          tgt_r <= in_target;
          wval_r <= in_wval;
          idx_r <= in_index;
          sat_r <= 1'b0;
          value_r <= '0;
          acc_r <= '0;
        end
        CMD_DEL: begin
          t_r <= delv;
          sat_r <= sat_r | delovf;
        end
        CMD_MAC_HID, CMD_MAC_OUT: begin
          acc_r <= acc_r + 66'(prod);
          sat_r <= sat_r | povf;
        end
        CMD_HID_DONE: begin
          act_r[ctl.unit[UW-1:0]] <= SIG_TAB[sig_index(accsat)];
          sat_r <= sat_r | aovf;
          acc_r <= '0;
        end
        CMD_OUT_DONE: begin
          value_r <= accsat;
          sat_r <= sat_r | aovf;
        end
        CMD_G: begin
          g_r <= prod;
          sat_r <= sat_r | povf;
        end
        CMD_GH1, CMD_GH2, CMD_GH3: begin
          t_r <= prod;
          sat_r <= sat_r | povf;
        end
        CMD_UPD_HID, CMD_UPD_OUT: sat_r <= sat_r | povf | dovf;
        CMD_WRITE: sat_r <= 1'b0;
        CMD_READ: value_r <= (idx_r < NW) ? rdata : '0;
        default: ;
      endcase
    end
  end

  assign res_value = value_r;
  assign res_sat   = sat_r;
endmodule

@@ hdl/mlp_ctrl.sv @@
// Controller: sequences forward pass, SGD update, weight write and read.
// Depends on mlp_pkg.
module mlp_ctrl
  import mlp_pkg::*;
#(
  parameter int FEATURES     = 6,
  parameter int HIDDEN_UNITS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  output logic       busy,
  output logic       done,
  output ctl_t       ctl
);
  localparam int HBASE = HIDDEN_UNITS * FEATURES;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_HRD, S_HMAC, S_HDONE, S_ORD, S_OMAC, S_ODONE,
    S_DEL, S_G, S_GH1, S_GH2, S_GH3, S_UHID, S_UOUT, S_FIN
  } state_t;

  state_t     state_r;
  logic [1:0] op_r;
  logic [3:0] unit_r;
  logic [2:0] feat_r;
  logic       ph_r;   // 0: issue read, 1: use data

  always_comb begin
    ctl = '{cmd: CMD_NONE, addr: '0, unit: unit_r, feat: feat_r, rd: 1'b0};
    unique case (state_r)
      S_LOAD: ctl.cmd = CMD_LOAD;
      S_HRD: begin
        ctl.addr = 7'(unit_r * FEATURES + feat_r);
        if (ph_r) ctl.cmd = CMD_MAC_HID;
      end
      S_HDONE: ctl.cmd = CMD_HID_DONE;
      S_ORD: begin
        ctl.addr = 7'(HBASE + unit_r);
        if (ph_r) ctl.cmd = CMD_MAC_OUT;
      end
      S_ODONE: ctl.cmd = CMD_OUT_DONE;
      S_DEL:   ctl.cmd = CMD_DEL;
      S_G:     ctl.cmd = CMD_G;
      S_GH1:   begin ctl.cmd = CMD_GH1; ctl.addr = 7'(HBASE + unit_r); end
      S_GH2:   begin ctl.cmd = CMD_GH2; ctl.addr = 7'(HBASE + unit_r); end
      S_GH3:   begin ctl.cmd = CMD_GH3; ctl.addr = 7'(HBASE + unit_r); end
      S_UHID: begin
        ctl.addr = 7'(unit_r * FEATURES + feat_r);
        if (ph_r) ctl.cmd = CMD_UPD_HID;
      end
      S_UOUT: begin
        ctl.addr = 7'(HBASE + unit_r);
        if (ph_r) ctl.cmd = CMD_UPD_OUT;
      end
      S_FIN: begin
        if (op_r == OP_WRITE) ctl.cmd = CMD_WRITE;
        if (op_r == OP_READ) begin
          ctl.rd = 1'b1;
          if (ph_r) ctl.cmd = CMD_READ;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= 1'b0;
      unit_r <= '0;
      feat_r <= '0;
      op_r <= OP_PREDICT;
      done <= 1'b0;
    end else begin
      done <= (state_r == S_FIN) && (op_r != OP_READ || ph_r);
      unique case (state_r)
        S_IDLE: if (start) begin
          op_r <= op;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          unit_r <= '0; feat_r <= '0; ph_r <= 1'b0;
          state_r <= (op_r == OP_PREDICT || op_r == OP_TRAIN) ? S_HRD : S_FIN;
        end
        S_HRD: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (feat_r == 3'(FEATURES - 1)) begin
              feat_r <= '0;
              state_r <= S_HDONE;
            end else feat_r <= feat_r + 3'd1;
          end
        end
        S_HDONE: begin
          if (unit_r == 4'(HIDDEN_UNITS - 1)) begin
            unit_r <= '0;
            state_r <= S_ORD;
          end else begin
            unit_r <= unit_r + 4'd1;
            state_r <= S_HRD;
          end
        end
        S_ORD: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (unit_r == 4'(HIDDEN_UNITS - 1)) begin
              unit_r <= '0;
              state_r <= S_ODONE;
            end else unit_r <= unit_r + 4'd1;
          end
        end
        S_ODONE: state_r <= (op_r == OP_TRAIN) ? S_DEL : S_FIN;
        S_DEL:   state_r <= S_G;
        S_G:     state_r <= S_GH1;
        S_GH1:   state_r <= S_GH2;
        S_GH2:   state_r <= S_GH3;
        S_GH3:   state_r <= S_UHID;
        S_UHID: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (feat_r == 3'(FEATURES - 1)) begin
              feat_r <= '0;
              if (unit_r == 4'(HIDDEN_UNITS - 1)) begin
                unit_r <= '0;
                state_r <= S_UOUT;
              end else begin
                unit_r <= unit_r + 4'd1;
                state_r <= S_GH1;
              end
            end else feat_r <= feat_r + 3'd1;
          end
        end
        S_UOUT: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            if (unit_r == 4'(HIDDEN_UNITS - 1)) begin
              unit_r <= '0;
              state_r <= S_FIN;
            end else unit_r <= unit_r + 4'd1;
          end
        end
        S_FIN: begin
          if (op_r == OP_READ && !ph_r) ph_r <= 1'b1;
          else begin
            ph_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
